>>> sv/chunked_bubble_then_merge_sorter_defines.svh
// assertion helpers shared by the sorter
`ifndef CHUNKED_BUBBLE_THEN_MERGE_SORTER_DEFINES_SVH
`define CHUNKED_BUBBLE_THEN_MERGE_SORTER_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define CBMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off while reset is asserted
`define CBMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/cbms_pkg.sv
`timescale 1ns / 1ps

package cbms_pkg;

	localparam int VAL_W   = 32;
	localparam int SWAP_W  = 11;
	localparam int TDATA_W = ((VAL_W + SWAP_W + 7) / 8) * 8;
	localparam int PAD_W   = TDATA_W - VAL_W - SWAP_W;

	typedef enum logic [4:0] {
		S_LOAD,
		S_SETUP,
		S_DIV,
		S_BRUN,
		S_BCHK,
		S_BP_C0,
		S_BP_CMP,
		S_BP_END,
		S_MSTEP,
		S_MSEG,
		S_MIA,
		S_MLA,
		S_MLB,
		S_MCMP,
		S_CPWR,
		S_OSTART,
		S_ORD,
		S_OWAIT
	} state_t;

	// source of the element store write data
	typedef enum logic [1:0] {
		WS_IN,
		WS_BUBBLE,
		WS_CARRY,
		WS_SCR
	} wsel_t;

	typedef enum logic [1:0] {
		CARRY_HOLD,
		CARRY_LOAD,
		CARRY_BUBBLE
	} carry_op_t;

	typedef struct packed {
		logic      st_we;
		wsel_t     st_wsel;
		logic      sc_we;
		logic      sc_take_b;
		carry_op_t carry_op;
		logic      a_ld;
		logic      b_ld;
		logic      swap_clr;
		logic      swap_inc;
		logic      out_ld;
		logic      out_final;
	} dp_cmd_t;

	typedef struct packed {
		logic carry_gt;
		logic a_gt_b;
		logic out_take;
	} dp_stat_t;

endpackage

>>> sv/cbms_dp.sv
`timescale 1ns / 1ps

module cbms_dp #(
	parameter int DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cbms_pkg::dp_cmd_t                   cmd,
	input  logic [$clog2(DEPTH)-1:0]            st_waddr,
	input  logic [$clog2(DEPTH)-1:0]            st_raddr,
	input  logic [$clog2(DEPTH)-1:0]            sc_waddr,
	input  logic [$clog2(DEPTH)-1:0]            sc_raddr,
	input  logic signed [cbms_pkg::VAL_W-1:0]   in_value,
	input  logic                                out_ready,
	output cbms_pkg::dp_stat_t                  stat,
	output logic                                out_valid,
	output logic                                out_last,
	output logic signed [cbms_pkg::VAL_W-1:0]   out_value,
	output logic [cbms_pkg::SWAP_W-1:0]         out_swaps
);

	logic signed [cbms_pkg::VAL_W-1:0] st_mem [DEPTH];
	logic signed [cbms_pkg::VAL_W-1:0] sc_mem [DEPTH];

	logic signed [cbms_pkg::VAL_W-1:0] rd_q;
	logic signed [cbms_pkg::VAL_W-1:0] sr_q;
	logic signed [cbms_pkg::VAL_W-1:0] carry_q;
	logic signed [cbms_pkg::VAL_W-1:0] a_q;
	logic signed [cbms_pkg::VAL_W-1:0] b_q;
	logic signed [cbms_pkg::VAL_W-1:0] out_value_q;
	logic [cbms_pkg::SWAP_W-1:0]       swap_q;
	logic                              out_valid_q;
	logic                              out_last_q;

	logic signed [cbms_pkg::VAL_W-1:0] st_wdata;
	logic signed [cbms_pkg::VAL_W-1:0] sc_wdata;
	logic                              carry_gt;
	logic                              out_take;

	assign carry_gt = carry_q > rd_q;
	assign out_take = out_valid_q & out_ready;
	assign sc_wdata = cmd.sc_take_b ? b_q : a_q;

	always_comb begin
		case (cmd.st_wsel)
			cbms_pkg::WS_IN:     st_wdata = in_value;
			cbms_pkg::WS_BUBBLE: st_wdata = carry_gt ? rd_q : carry_q;
			cbms_pkg::WS_CARRY:  st_wdata = carry_q;
			cbms_pkg::WS_SCR:    st_wdata = sr_q;
			default:             st_wdata = in_value;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.st_we) begin
			st_mem[st_waddr] <= st_wdata;
		end
		rd_q <= st_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.sc_we) begin
			sc_mem[sc_waddr] <= sc_wdata;
		end
		sr_q <= sc_mem[sc_raddr];
	end

	// carry keeps the larger value as it bubbles up the run
	always_ff @(posedge clk) begin
		case (cmd.carry_op)
			cbms_pkg::CARRY_LOAD:   carry_q <= rd_q;
			cbms_pkg::CARRY_BUBBLE: carry_q <= carry_gt ? carry_q : rd_q;
			default:                carry_q <= carry_q;
		endcase
		if (cmd.a_ld) begin
			a_q <= rd_q;
		end
		if (cmd.b_ld) begin
			b_q <= rd_q;
		end
		if (cmd.out_ld) begin
			out_value_q <= rd_q;
			out_last_q  <= cmd.out_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.swap_clr) begin
				swap_q <= '0;
			end else if (cmd.swap_inc && carry_gt) begin
				swap_q <= swap_q + cbms_pkg::SWAP_W'(1);
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.carry_gt = carry_gt;
	assign stat.a_gt_b   = a_q > b_q;
	assign stat.out_take = out_take;

	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;
	assign out_value = out_value_q;
	assign out_swaps = swap_q;

endmodule

>>> sv/cbms_ctrl.sv
`timescale 1ns / 1ps

module cbms_ctrl #(
	parameter int DEPTH  = 64,
	parameter int CHUNKS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_last,
	output logic                     in_ready,
	input  cbms_pkg::dp_stat_t       stat,
	output cbms_pkg::dp_cmd_t        cmd,
	output logic [$clog2(DEPTH)-1:0] st_waddr,
	output logic [$clog2(DEPTH)-1:0] st_raddr,
	output logic [$clog2(DEPTH)-1:0] sc_waddr,
	output logic [$clog2(DEPTH)-1:0] sc_raddr
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = CW + 2;
	localparam logic [CW-1:0] CHUNK_C = CW'(CHUNKS);

	cbms_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] rem_q, rem_d;
	logic [CW-1:0] width_q, width_d;
	logic [CW-1:0] runs_q, runs_d;
	logic [CW-1:0] r_q, r_d;
	logic [CW-1:0] lo_q, lo_d;
	logic [CW-1:0] end_q, end_d;
	logic [CW-1:0] j_q, j_d;
	logic [CW:0]   step_q, step_d;
	logic [XW-1:0] i_q, i_d;
	logic [CW-1:0] mid_q, mid_d;
	logic [CW-1:0] hi_q, hi_d;
	logic [CW-1:0] ia_q, ia_d;
	logic [CW-1:0] ja_q, ja_d;
	logic [CW-1:0] k_q, k_d;
	logic [CW-1:0] c_q, c_d;
	logic          a_done_q, a_done_d;
	logic          b_done_q, b_done_d;

	logic [XW-1:0] n_x, nm1_x, step_x, seg_mid_x, seg_hi_x, seg_next_x;
	logic [CW-1:0] mid_c, hi_c, run_hi, cp_addr;
	logic          take_b;

	assign n_x        = XW'(count_q);
	assign nm1_x      = n_x - XW'(1);
	assign step_x     = XW'(step_q);
	assign seg_mid_x  = i_q + step_x - XW'(1);
	assign seg_hi_x   = i_q + (step_x << 1) - XW'(1);
	assign seg_next_x = i_q + (step_x << 1);
	assign mid_c      = (seg_mid_x > nm1_x) ? nm1_x[CW-1:0] : seg_mid_x[CW-1:0];
	assign hi_c       = (seg_hi_x > nm1_x) ? nm1_x[CW-1:0] : seg_hi_x[CW-1:0];
	// last run stretches to the end of the set
	assign run_hi     = (r_q + CW'(1) == runs_q) ? count_q : lo_q + width_q;
	assign cp_addr    = i_q[CW-1:0] + c_q;
	assign take_b     = a_done_q | (~b_done_q & stat.a_gt_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbms_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rem_q    <= '0;
			width_q  <= '0;
			runs_q   <= '0;
			r_q      <= '0;
			lo_q     <= '0;
			end_q    <= '0;
			j_q      <= '0;
			step_q   <= '0;
			i_q      <= '0;
			mid_q    <= '0;
			hi_q     <= '0;
			ia_q     <= '0;
			ja_q     <= '0;
			k_q      <= '0;
			c_q      <= '0;
			a_done_q <= 1'b0;
			b_done_q <= 1'b0;
		end else begin
			count_q  <= count_d;
			rem_q    <= rem_d;
			width_q  <= width_d;
			runs_q   <= runs_d;
			r_q      <= r_d;
			lo_q     <= lo_d;
			end_q    <= end_d;
			j_q      <= j_d;
			step_q   <= step_d;
			i_q      <= i_d;
			mid_q    <= mid_d;
			hi_q     <= hi_d;
			ia_q     <= ia_d;
			ja_q     <= ja_d;
			k_q      <= k_d;
			c_q      <= c_d;
			a_done_q <= a_done_d;
			b_done_q <= b_done_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		rem_d    = rem_q;
		width_d  = width_q;
		runs_d   = runs_q;
		r_d      = r_q;
		lo_d     = lo_q;
		end_d    = end_q;
		j_d      = j_q;
		step_d   = step_q;
		i_d      = i_q;
		mid_d    = mid_q;
		hi_d     = hi_q;
		ia_d     = ia_q;
		ja_d     = ja_q;
		k_d      = k_q;
		c_d      = c_q;
		a_done_d = a_done_q;
		b_done_d = b_done_q;
		cmd      = '0;
		in_ready = 1'b0;
		st_waddr = '0;
		st_raddr = '0;
		sc_waddr = '0;
		sc_raddr = '0;

		case (state_q)
			cbms_pkg::S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					// a full store drops further values
					if (int'(count_q) < DEPTH) begin
						cmd.st_we   = 1'b1;
						cmd.st_wsel = cbms_pkg::WS_IN;
						st_waddr    = count_q[AW-1:0];
						count_d     = count_q + CW'(1);
					end
					if (in_last) begin
						state_d = cbms_pkg::S_SETUP;
					end
				end
			end

			cbms_pkg::S_SETUP: begin
				cmd.swap_clr = 1'b1;
				rem_d        = count_q;
				r_d          = '0;
				lo_d         = '0;
				if (int'(count_q) < CHUNKS) begin
					width_d = CW'(1);
					runs_d  = count_q;
					state_d = cbms_pkg::S_BRUN;
				end else begin
					width_d = '0;
					runs_d  = CHUNK_C;
					state_d = cbms_pkg::S_DIV;
				end
			end

			// run width by repeated subtraction
			cbms_pkg::S_DIV: begin
				if (int'(rem_q) >= CHUNKS) begin
					rem_d   = rem_q - CHUNK_C;
					width_d = width_q + CW'(1);
				end else begin
					state_d = cbms_pkg::S_BRUN;
				end
			end

			cbms_pkg::S_BRUN: begin
				if (r_q == runs_q) begin
					step_d  = {1'b0, width_q};
					state_d = cbms_pkg::S_MSTEP;
				end else begin
					end_d   = run_hi;
					state_d = cbms_pkg::S_BCHK;
				end
			end

			cbms_pkg::S_BCHK: begin
				if (end_q - lo_q >= CW'(2)) begin
					j_d      = lo_q;
					st_raddr = lo_q[AW-1:0];
					state_d  = cbms_pkg::S_BP_C0;
				end else begin
					r_d     = r_q + CW'(1);
					lo_d    = lo_q + width_q;
					state_d = cbms_pkg::S_BRUN;
				end
			end

			cbms_pkg::S_BP_C0: begin
				cmd.carry_op = cbms_pkg::CARRY_LOAD;
				st_raddr     = AW'(j_q + CW'(1));
				state_d      = cbms_pkg::S_BP_CMP;
			end

			cbms_pkg::S_BP_CMP: begin
				cmd.st_we    = 1'b1;
				cmd.st_wsel  = cbms_pkg::WS_BUBBLE;
				cmd.carry_op = cbms_pkg::CARRY_BUBBLE;
				cmd.swap_inc = 1'b1;
				st_waddr     = j_q[AW-1:0];
				j_d          = j_q + CW'(1);
				if (j_q + CW'(2) < end_q) begin
					st_raddr = AW'(j_q + CW'(2));
				end else begin
					state_d = cbms_pkg::S_BP_END;
				end
			end

			cbms_pkg::S_BP_END: begin
				cmd.st_we   = 1'b1;
				cmd.st_wsel = cbms_pkg::WS_CARRY;
				st_waddr    = j_q[AW-1:0];
				end_d       = end_q - CW'(1);
				state_d     = cbms_pkg::S_BCHK;
			end

			cbms_pkg::S_MSTEP: begin
				if (step_q >= {1'b0, count_q}) begin
					k_d     = '0;
					state_d = cbms_pkg::S_OSTART;
				end else begin
					i_d     = '0;
					state_d = cbms_pkg::S_MSEG;
				end
			end

			cbms_pkg::S_MSEG: begin
				if (i_q >= n_x) begin
					step_d  = step_q << 1;
					state_d = cbms_pkg::S_MSTEP;
				end else if (mid_c < hi_c) begin
					mid_d    = mid_c;
					hi_d     = hi_c;
					ia_d     = i_q[CW-1:0];
					ja_d     = mid_c + CW'(1);
					k_d      = '0;
					a_done_d = 1'b0;
					b_done_d = 1'b0;
					st_raddr = i_q[AW-1:0];
					state_d  = cbms_pkg::S_MIA;
				end else begin
					// single trailing run stays in place
					i_d = seg_next_x;
				end
			end

			cbms_pkg::S_MIA: begin
				cmd.a_ld = 1'b1;
				st_raddr = ja_q[AW-1:0];
				state_d  = cbms_pkg::S_MLB;
			end

			cbms_pkg::S_MLA: begin
				cmd.a_ld = 1'b1;
				state_d  = cbms_pkg::S_MCMP;
			end

			cbms_pkg::S_MLB: begin
				cmd.b_ld = 1'b1;
				state_d  = cbms_pkg::S_MCMP;
			end

			// ties go to the left run
			cbms_pkg::S_MCMP: begin
				if (a_done_q && b_done_q) begin
					c_d      = '0;
					sc_raddr = '0;
					state_d  = cbms_pkg::S_CPWR;
				end else begin
					cmd.sc_we     = 1'b1;
					cmd.sc_take_b = take_b;
					sc_waddr      = k_q[AW-1:0];
					k_d           = k_q + CW'(1);
					if (take_b) begin
						ja_d = ja_q + CW'(1);
						if (ja_q == hi_q) begin
							b_done_d = 1'b1;
						end else begin
							st_raddr = AW'(ja_q + CW'(1));
							state_d  = cbms_pkg::S_MLB;
						end
					end else begin
						ia_d = ia_q + CW'(1);
						if (ia_q == mid_q) begin
							a_done_d = 1'b1;
						end else begin
							st_raddr = AW'(ia_q + CW'(1));
							state_d  = cbms_pkg::S_MLA;
						end
					end
				end
			end

			// copy the merged segment back, one entry a cycle
			cbms_pkg::S_CPWR: begin
				cmd.st_we   = 1'b1;
				cmd.st_wsel = cbms_pkg::WS_SCR;
				st_waddr    = cp_addr[AW-1:0];
				c_d         = c_q + CW'(1);
				if (c_q + CW'(1) < k_q) begin
					sc_raddr = AW'(c_q + CW'(1));
				end else begin
					i_d     = seg_next_x;
					state_d = cbms_pkg::S_MSEG;
				end
			end

			cbms_pkg::S_OSTART: begin
				st_raddr = k_q[AW-1:0];
				state_d  = cbms_pkg::S_ORD;
			end

			cbms_pkg::S_ORD: begin
				cmd.out_ld    = 1'b1;
				cmd.out_final = (k_q + CW'(1) == count_q);
				state_d       = cbms_pkg::S_OWAIT;
			end

			cbms_pkg::S_OWAIT: begin
				if (stat.out_take) begin
					k_d = k_q + CW'(1);
					if (k_q + CW'(1) == count_q) begin
						count_d      = '0;
						cmd.swap_clr = 1'b1;
						state_d      = cbms_pkg::S_LOAD;
					end else begin
						st_raddr = AW'(k_q + CW'(1));
						state_d  = cbms_pkg::S_ORD;
					end
				end
			end

			default: begin
				state_d = cbms_pkg::S_LOAD;
			end
		endcase
	end

endmodule

>>> sv/chunked_bubble_then_merge_sorter.sv
`timescale 1ns / 1ps
// sorts a set of up to DEPTH signed 32-bit values
// s_* channel: one value per request; s_tlast marks the final value of the set and
//   starts the sort. s_tready is high only while loading; values past DEPTH are dropped.
// m_* channel: the set in ascending order, one value per request, m_tlast on the last;
//   every result carries the total swap count of the run sort phase.
// loading accepts a value whenever s_tvalid is high. after the final value the set is cut
//   into min(CHUNKS, n) runs, each bubble sorted with one compare a cycle, then merged
//   bottom-up through the scratch store and copied back, one pass per doubling of the
//   run width until it covers the set. the element store takes one read and one write a
//   cycle. each result is read from the store only after the one before it has been
//   taken, so no new result is presented while the current one waits.
// a stalled receiver holds the current result in the output register; the sort
//   waits and no new value is taken until the last result of the set has gone.
// reset (arst_n low) empties the set and clears the swap count; store contents
//   are not cleared and are only read after being written for the current set.
module chunked_bubble_then_merge_sorter #(
	parameter int DEPTH  = 64,
	parameter int CHUNKS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cbms_pkg::VAL_W-1:0]    s_tdata,  // value[31:0]
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cbms_pkg::TDATA_W-1:0]  m_tdata,  // sorted_value[31:0], swap_total[42:32], zero
	output logic                          m_tlast
);

	`include "chunked_bubble_then_merge_sorter_defines.svh"

	localparam int AW = $clog2(DEPTH);

	cbms_pkg::dp_cmd_t  cmd;
	cbms_pkg::dp_stat_t stat;

	logic [AW-1:0]                     st_waddr;
	logic [AW-1:0]                     st_raddr;
	logic [AW-1:0]                     sc_waddr;
	logic [AW-1:0]                     sc_raddr;
	logic signed [cbms_pkg::VAL_W-1:0] out_value;
	logic [cbms_pkg::SWAP_W-1:0]       out_swaps;

	cbms_ctrl #(
		.DEPTH  (DEPTH),
		.CHUNKS (CHUNKS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd),
		.st_waddr (st_waddr),
		.st_raddr (st_raddr),
		.sc_waddr (sc_waddr),
		.sc_raddr (sc_raddr)
	);

	cbms_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st_waddr  (st_waddr),
		.st_raddr  (st_raddr),
		.sc_waddr  (sc_waddr),
		.sc_raddr  (sc_raddr),
		.in_value  (s_tdata),
		.out_ready (m_tready),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_last  (m_tlast),
		.out_value (out_value),
		.out_swaps (out_swaps)
	);

	assign m_tdata = {{cbms_pkg::PAD_W{1'b0}}, out_swaps, out_value};

	`CBMS_ASSERT_IMP(a_no_load_during_output, clk, arst_n, s_tready, !m_tvalid,
		"value taken while a result waits")
	`CBMS_ASSERT_NXT(a_load_after_last, clk, arst_n, m_tvalid && m_tready && m_tlast,
		s_tready && !m_tvalid, "block not ready after the last result")
	`CBMS_ASSERT_IMP(a_swaps_steady, clk, arst_n, m_tvalid && $past(m_tvalid),
		$stable(out_swaps), "swap total moved during output")

endmodule

>>> sim/chunked_bubble_then_merge_sorter_test.sv
`timescale 1ns / 1ps

module chunked_bubble_then_merge_sorter_test;

	localparam int DEPTH        = 64;
	localparam int CHUNKS       = 16;
	localparam int STALL_CYCLES = 3000;
	localparam int IDLE_LIMIT   = 20000;
	localparam int TAIL_CYCLES  = 200;
	localparam int ITEM_TARGET  = 450;

	typedef enum {
		FILL_RANDOM,
		FILL_TIES,
		FILL_EXTREMES,
		FILL_DESCENDING
	} fill_mode_t;

	typedef struct packed {
		logic signed [cbms_pkg::VAL_W-1:0] sorted_value;
		logic                              final_res;
		logic [cbms_pkg::SWAP_W-1:0]       swap_total;
	} sorted_result_t;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [cbms_pkg::VAL_W-1:0]   s_tdata  = '0;
	logic                         s_tlast  = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [cbms_pkg::TDATA_W-1:0] m_tdata;
	logic                         m_tlast;

	// shadow of the block's set and the sorted values still to come out
	logic signed [cbms_pkg::VAL_W-1:0] set_values [DEPTH];
	logic signed [cbms_pkg::VAL_W-1:0] merge_buf  [DEPTH];
	int                                set_count = 0;
	sorted_result_t                    sorted_queue [$];

	logic           no_idle     = 1'b0;
	logic           stall_start = 1'b0;
	int             items_sent  = 0;
	int             error_count = 0;
	int             idle_cycles = 0;
	int             stall_left  = 0;
	sorted_result_t want;

	chunked_bubble_then_merge_sorter #(
		.DEPTH (DEPTH),
		.CHUNKS(CHUNKS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// merge [lo..mid] with [mid+1..hi], ties from the left run
	function automatic void merge_span(input int lo, input int mid, input int hi);
		int i, j, k;
		i = lo;
		j = mid + 1;
		k = 0;
		while (i <= mid && j <= hi) begin
			if (set_values[i] <= set_values[j]) begin
				merge_buf[k] = set_values[i];
				i++;
			end else begin
				merge_buf[k] = set_values[j];
				j++;
			end
			k++;
		end
		while (i <= mid) begin
			merge_buf[k] = set_values[i];
			i++;
			k++;
		end
		while (j <= hi) begin
			merge_buf[k] = set_values[j];
			j++;
			k++;
		end
		for (int m = 0; m < k; m++)
			set_values[lo + m] = merge_buf[m];
	endfunction

	// store one accepted value; on the last one sort the set and queue its results
	function automatic void store_and_sort(input logic [cbms_pkg::VAL_W-1:0] value,
	                                       input logic is_last);
		int                                n, runs, width, lo, hi, mid, top, step;
		logic [cbms_pkg::SWAP_W-1:0]       swaps;
		logic signed [cbms_pkg::VAL_W-1:0] tmp;
		sorted_result_t                    res;
		if (set_count < DEPTH) begin
			set_values[set_count] = value;
			set_count++;
		end
		if (!is_last)
			return;
		n     = set_count;
		runs  = (n < CHUNKS) ? n : CHUNKS;
		width = n / runs;
		swaps = '0;
		for (int r = 0; r < runs; r++) begin
			lo = r * width;
			hi = (r + 1 == runs) ? n : lo + width;
			for (int p = 0; p + 1 < hi - lo; p++) begin
				for (int j = lo; j + 1 < hi - p; j++) begin
					if (set_values[j] > set_values[j + 1]) begin
						tmp               = set_values[j];
						set_values[j]     = set_values[j + 1];
						set_values[j + 1] = tmp;
						swaps++;
					end
				end
			end
		end
		for (step = width; step < n; step *= 2) begin
			for (int i = 0; i < n; i += 2 * step) begin
				mid = (i + step - 1 > n - 1) ? n - 1 : i + step - 1;
				top = (i + 2 * step - 1 > n - 1) ? n - 1 : i + 2 * step - 1;
				if (mid < top)
					merge_span(i, mid, top);
			end
		end
		for (int k = 0; k < n; k++) begin
			res.sorted_value = set_values[k];
			res.final_res    = (k + 1 == n);
			res.swap_total   = swaps;
			sorted_queue     = {sorted_queue, res};
		end
		set_count = 0;
	endfunction

	task automatic send_value(input logic [cbms_pkg::VAL_W-1:0] value, input logic is_last);
		while (!no_idle && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= is_last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		store_and_sort(value, is_last);
	endtask

	task automatic send_set(input int n, input fill_mode_t mode);
		logic [cbms_pkg::VAL_W-1:0] base, stride, value;
		base   = $urandom;
		stride = $urandom_range(1, 100000);
		for (int i = 0; i < n; i++) begin
			case (mode)
				FILL_TIES:       value = $urandom_range(0, 5) - 2;
				FILL_EXTREMES: begin
					case ($urandom_range(3))
						0:       value = 32'h8000_0000;
						1:       value = 32'h7fff_ffff;
						2:       value = 32'h0000_0000;
						default: value = 32'hffff_ffff;
					endcase
				end
				FILL_DESCENDING: value = base - i * stride;
				default:         value = $urandom;
			endcase
			send_value(value, i == n - 1);
		end
	endtask

	// stop offering and let every queued result come out
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sorted_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		logic [cbms_pkg::VAL_W-1:0] corner [7];
		corner = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
		           32'h8000_0000, 32'h1, 32'h7fff_ffff};
		// a set of one, taken straight to the output
		send_value(32'h8000_0000, 1'b1);
		// fewer values than runs, extremes and ties
		for (int i = 0; i < 7; i++)
			send_value(corner[i], i == 6);
		// count not a multiple of the run count, so the final run is longer
		for (int i = 0; i < 17; i++)
			send_value(16 - i, i == 16);
		wait_for_results();
	endtask

	task automatic test_full_store();
		send_set(DEPTH, FILL_RANDOM);
		wait_for_results();
	endtask

	task automatic test_overflow();
		// the last few values, the marked one among them, fall off the end
		send_set(DEPTH + 6, FILL_DESCENDING);
		wait_for_results();
	endtask

	task automatic test_receiver_stall();
		stall_start <= 1'b1;
		@(posedge clk);
		stall_start <= 1'b0;
		send_set(40, FILL_RANDOM);
		send_set(30, FILL_TIES);
		wait_for_results();
	endtask

	task automatic test_random_sets();
		int         n, sets;
		fill_mode_t mode;
		sets = 0;
		while (items_sent < ITEM_TARGET) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 8)
			                             : $urandom_range(1, 40);
			case ($urandom_range(5))
				0:       mode = FILL_TIES;
				1:       mode = FILL_EXTREMES;
				2:       mode = FILL_DESCENDING;
				default: mode = FILL_RANDOM;
			endcase
			// a few sets run without any idling on either side
			no_idle <= (sets >= 3 && sets < 6);
			send_set(n, mode);
			sets++;
		end
		no_idle <= 1'b0;
		wait_for_results();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_store();
		test_overflow();
		test_receiver_stall();
		test_random_sets();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sorted_queue.size() != 0) begin
			$error("%0d sorted values never came out", sorted_queue.size());
			error_count++;
		end
		if (error_count == 0)
			$display("chunked_bubble_then_merge_sorter_test: clean");
		else
			$display("chunked_bubble_then_merge_sorter_test: errors");
		$finish;
	end

	// receiver: random idling, or a long hold-off when asked
	always @(posedge clk) begin
		if (stall_start)
			stall_left = STALL_CYCLES;
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(99) >= 11);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (sorted_queue.size() == 0) begin
				$error("result with nothing queued: tdata %h tlast %b", m_tdata, m_tlast);
				error_count++;
			end else begin
				want = sorted_queue.pop_front();
				if (m_tdata[cbms_pkg::VAL_W-1:0] !== want.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d",
					       want.sorted_value, $signed(m_tdata[cbms_pkg::VAL_W-1:0]));
					error_count++;
				end
				if (m_tlast !== want.final_res) begin
					$error("final_res: expected %b, got %b", want.final_res, m_tlast);
					error_count++;
				end
				if (m_tdata[cbms_pkg::VAL_W+cbms_pkg::SWAP_W-1:cbms_pkg::VAL_W]
				    !== want.swap_total) begin
					$error("swap_total: expected %0d, got %0d", want.swap_total,
					       m_tdata[cbms_pkg::VAL_W+cbms_pkg::SWAP_W-1:cbms_pkg::VAL_W]);
					error_count++;
				end
			end
		end
	end

	// gives up when no request moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("chunked_bubble_then_merge_sorter_test: errors");
			$finish;
		end
	end

endmodule
